FILE: hw/rtl/assert_macros.svh
// Assertion macros used by the checker module of the set filter.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on a given clock, disabled while the reset is low.
`define ASSERT_CLK(lbl, clk_s, rst_s, prop) \
    lbl: assert property (@(posedge clk_s) disable iff (!rst_s) prop) \
        else $error("concurrent assertion failed");

// Concurrent assertion on the usual clk and rst_n of the enclosing module.
`define ASSERT_DEF(lbl, prop) `ASSERT_CLK(lbl, clk, rst_n, prop)

`endif

FILE: hw/rtl/suf_pkg.sv
// Types, codes and helper functions of the sorted unique set filter.
`default_nettype none

package suf_pkg;

    localparam int DATA_W       = 32;
    localparam int CMD_W        = 3;
    localparam int STATUS_W     = 3;
    localparam int CAPACITY_DEF = 16;

    // Command codes carried on the input tuser.
    typedef enum logic [CMD_W-1:0] {
        CMD_INSERT   = 3'd0,
        CMD_DELETE   = 3'd1,
        CMD_DROP_POS = 3'd2,
        CMD_DROP_NEG = 3'd3,
        CMD_DROP_EVN = 3'd4,
        CMD_LIST     = 3'd5
    } cmd_t;

    // Status codes carried on the output tuser.
    typedef enum logic [STATUS_W-1:0] {
        ST_DONE     = 3'd0,
        ST_DUP      = 3'd1,
        ST_NOTFOUND = 3'd2,
        ST_FULL     = 3'd3,
        ST_ENTRY    = 3'd4,
        ST_EMPTY    = 3'd5
    } status_t;

    // Control sequencer states.
    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_FILTER,
        S_LIST
    } state_t;

    // Operation that every cell of the chain performs in a cycle.
    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_INSERT,
        CELL_DELETE,
        CELL_MARK,
        CELL_SWAP,
        CELL_ROTATE
    } cell_op_t;

    // Broadcast control from the sequencer to all cells.
    typedef struct packed {
        cell_op_t           op;
        logic [DATA_W-1:0]  value;
        cmd_t               kind;
        logic               parity;
    } cell_ctrl_t;

    // Signed less-than, done as unsigned compare with the sign bit flipped.
    function automatic logic key_less(input logic [DATA_W-1:0] a,
                                      input logic [DATA_W-1:0] b);
        return {~a[DATA_W-1], a[DATA_W-2:0]} < {~b[DATA_W-1], b[DATA_W-2:0]};
    endfunction

    // True when the selected bulk filter removes the value; zero always stays.
    function automatic logic drop_match(input cmd_t kind,
                                        input logic [DATA_W-1:0] v);
        logic nonzero;
        logic result;
        nonzero = (v != '0);
        case (kind)
            CMD_DROP_POS: result = nonzero && !v[DATA_W-1];
            CMD_DROP_NEG: result = v[DATA_W-1];
            default:      result = nonzero && !v[0];
        endcase
        return result;
    endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/sorted_unique_set_filter.sv
// Sorted set of distinct signed 32-bit values held in a chain of cells. A
// command is one transfer on the slave side, with the command code in tuser and
// the operand in tdata; every result is one transfer on the master side, with
// the status in tuser, the listed value in tdata and tlast on the final result.
// One command is in work at a time. Insert and delete take the transfer and a
// step in which every cell compares the operand at once and shifts in place;
// the unused codes only give the result. A bulk filter marks the entries, runs
// CAPACITY odd-even swap phases along the chain that push the dropped entries
// to the tail, and then gives the result. List rotates the whole ring once,
// handing one entry per cycle out of the head cell while the output does not
// stall. No clearing pass is needed after reset: the set starts empty.
`default_nettype none

module sorted_unique_set_filter #(
    parameter int CAPACITY = suf_pkg::CAPACITY_DEF
) (
    input  wire                            clk,
    input  wire                            rst_n,
    input  wire                            s_tvalid,
    output logic                           s_tready,
    input  wire  [suf_pkg::DATA_W-1:0]     s_tdata,   // [31:0] value
    input  wire  [suf_pkg::CMD_W-1:0]      s_tuser,   // [2:0] cmd
    output logic                           m_tvalid,
    input  wire                            m_tready,
    output logic [suf_pkg::DATA_W-1:0]     m_tdata,   // [31:0] entry
    output logic [suf_pkg::STATUS_W-1:0]   m_tuser,   // [2:0] status
    output logic                           m_tlast
);

    localparam int CNT_W = $clog2(CAPACITY + 1);

    suf_pkg::state_t              state_reg;
    suf_pkg::state_t              state_next;
    suf_pkg::cmd_t                cmd_reg;
    logic [suf_pkg::DATA_W-1:0]   value_reg;
    logic [CNT_W-1:0]             count_reg;
    logic [CNT_W-1:0]             count_next;
    logic [CNT_W-1:0]             step_reg;
    logic [CNT_W-1:0]             step_next;

    logic                         m_tvalid_reg;
    logic [suf_pkg::DATA_W-1:0]   m_tdata_reg;
    suf_pkg::status_t             m_status_reg;
    logic                         m_tlast_reg;

    logic                         res_we;
    suf_pkg::status_t             res_status;
    logic [suf_pkg::DATA_W-1:0]   res_entry;
    logic                         res_last;

    suf_pkg::cell_ctrl_t          ctrl;
    logic                         match;
    logic [CNT_W-1:0]             kept_count;
    logic [suf_pkg::DATA_W-1:0]   head_value;

    logic                         in_xfer;
    logic                         out_free;
    logic                         list_emit;
    logic                         list_go;
    logic                         filter_end;

    assign in_xfer    = s_tvalid && s_tready;
    assign out_free   = !m_tvalid_reg || m_tready;
    assign list_emit  = (step_reg < count_reg);
    assign list_go    = list_emit ? out_free : 1'b1;
    assign filter_end = (step_reg == CNT_W'(CAPACITY));

    // Next-state logic of the command sequencer.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            suf_pkg::S_IDLE:
            begin
                if (in_xfer)
                begin
                    state_next = suf_pkg::S_EXEC;
                end
            end
            suf_pkg::S_EXEC:
            begin
                case (cmd_reg) inside
                    suf_pkg::CMD_DROP_POS, suf_pkg::CMD_DROP_NEG, suf_pkg::CMD_DROP_EVN:
                    begin
                        state_next = suf_pkg::S_FILTER;
                    end
                    suf_pkg::CMD_LIST:
                    begin
                        if (count_reg != '0)
                        begin
                            state_next = suf_pkg::S_LIST;
                        end
                        else if (out_free)
                        begin
                            state_next = suf_pkg::S_IDLE;
                        end
                    end
                    default:
                    begin
                        if (out_free)
                        begin
                            state_next = suf_pkg::S_IDLE;
                        end
                    end
                endcase
            end
            suf_pkg::S_FILTER:
            begin
                if (filter_end && out_free)
                begin
                    state_next = suf_pkg::S_IDLE;
                end
            end
            suf_pkg::S_LIST:
            begin
                if (list_go && (step_reg == CNT_W'(CAPACITY - 1)))
                begin
                    state_next = suf_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = suf_pkg::S_IDLE;
            end
        endcase
    end

    // Output logic: cell operation, result write, count and step updates.
    always_comb
    begin
        s_tready    = 1'b0;
        ctrl.op     = suf_pkg::CELL_HOLD;
        ctrl.value  = value_reg;
        ctrl.kind   = cmd_reg;
        ctrl.parity = step_reg[0];
        res_we      = 1'b0;
        res_status  = suf_pkg::ST_DONE;
        res_entry   = '0;
        res_last    = 1'b1;
        count_next  = count_reg;
        step_next   = step_reg;
        unique case (state_reg)
            suf_pkg::S_IDLE:
            begin
                s_tready = 1'b1;
            end
            suf_pkg::S_EXEC:
            begin
                case (cmd_reg) inside
                    suf_pkg::CMD_INSERT:
                    begin
                        if (out_free)
                        begin
                            res_we = 1'b1;
                            if (match)
                            begin
                                res_status = suf_pkg::ST_DUP;
                            end
                            else if (count_reg == CNT_W'(CAPACITY))
                            begin
                                res_status = suf_pkg::ST_FULL;
                            end
                            else
                            begin
                                ctrl.op    = suf_pkg::CELL_INSERT;
                                count_next = count_reg + CNT_W'(1);
                            end
                        end
                    end
                    suf_pkg::CMD_DELETE:
                    begin
                        if (out_free)
                        begin
                            res_we = 1'b1;
                            if (match)
                            begin
                                ctrl.op    = suf_pkg::CELL_DELETE;
                                count_next = count_reg - CNT_W'(1);
                            end
                            else
                            begin
                                res_status = suf_pkg::ST_NOTFOUND;
                            end
                        end
                    end
                    suf_pkg::CMD_DROP_POS, suf_pkg::CMD_DROP_NEG, suf_pkg::CMD_DROP_EVN:
                    begin
                        ctrl.op   = suf_pkg::CELL_MARK;
                        step_next = '0;
                    end
                    suf_pkg::CMD_LIST:
                    begin
                        step_next = '0;
                        if ((count_reg == '0) && out_free)
                        begin
                            res_we     = 1'b1;
                            res_status = suf_pkg::ST_EMPTY;
                        end
                    end
                    default:
                    begin
                        res_we = out_free;
                    end
                endcase
            end
            suf_pkg::S_FILTER:
            begin
                if (filter_end)
                begin
                    if (out_free)
                    begin
                        res_we     = 1'b1;
                        count_next = kept_count;
                    end
                end
                else
                begin
                    ctrl.op   = suf_pkg::CELL_SWAP;
                    step_next = step_reg + CNT_W'(1);
                end
            end
            suf_pkg::S_LIST:
            begin
                // The head entry leaves while the ring moves one place.
                if (list_go)
                begin
                    ctrl.op   = suf_pkg::CELL_ROTATE;
                    step_next = step_reg + CNT_W'(1);
                    if (list_emit)
                    begin
                        res_we     = 1'b1;
                        res_status = suf_pkg::ST_ENTRY;
                        res_entry  = head_value;
                        res_last   = (step_reg == count_reg - CNT_W'(1));
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= suf_pkg::S_IDLE;
            cmd_reg      <= suf_pkg::CMD_INSERT;
            count_reg    <= '0;
            step_reg     <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            step_reg  <= step_next;
            if (in_xfer)
            begin
                cmd_reg <= suf_pkg::cmd_t'(s_tuser);
            end
            if (res_we)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // Operand and result payload registers.
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            value_reg <= s_tdata;
        end
        if (res_we)
        begin
            m_tdata_reg  <= res_entry;
            m_status_reg <= res_status;
            m_tlast_reg  <= res_last;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_status_reg;
    assign m_tlast  = m_tlast_reg;

    suf_chain #(
        .CAPACITY (CAPACITY),
        .CNT_W    (CNT_W)
    ) u_chain (
        .clk        (clk),
        .ctrl       (ctrl),
        .count      (count_reg),
        .match      (match),
        .kept_count (kept_count),
        .head_value (head_value)
    );

endmodule

`default_nettype wire

FILE: hw/rtl/suf_cell.sv
// One storage cell of the sorted chain: holds an entry and a drop mark.
`default_nettype none

module suf_cell #(
    parameter int CAPACITY = suf_pkg::CAPACITY_DEF,
    parameter int INDEX    = 0,
    parameter int CNT_W    = $clog2(CAPACITY + 1)
) (
    input  wire                          clk,
    input  wire  suf_pkg::cell_ctrl_t    ctrl,
    input  wire  [CNT_W-1:0]             count,
    input  wire  [suf_pkg::DATA_W-1:0]   left_value,
    input  wire                          left_lt,
    input  wire                          left_drop,
    input  wire  [suf_pkg::DATA_W-1:0]   right_value,
    input  wire                          right_drop,
    output logic [suf_pkg::DATA_W-1:0]   value,
    output logic                         lt,
    output logic                         eq,
    output logic                         drop
);

    localparam logic RIGHT_PAR = 1'(INDEX % 2);
    localparam logic LEFT_PAR  = ~RIGHT_PAR;
    localparam logic HAS_RIGHT = (INDEX < CAPACITY - 1);
    localparam logic HAS_LEFT  = (INDEX > 0);
    localparam logic IS_HEAD   = (INDEX == 0);

    logic [suf_pkg::DATA_W-1:0] value_reg;
    logic [suf_pkg::DATA_W-1:0] value_next;
    logic                       drop_reg;
    logic                       drop_next;
    logic                       occupied;

    // The cell holds a live entry when its position is below the fill count.
    assign occupied = (count > CNT_W'(INDEX));
    assign lt       = occupied && suf_pkg::key_less(value_reg, ctrl.value);
    assign eq       = occupied && (value_reg == ctrl.value);
    assign value    = value_reg;
    assign drop     = drop_reg;

    // Per-cell update for the broadcast operation.
    always_comb
    begin
        value_next = value_reg;
        drop_next  = drop_reg;
        unique case (ctrl.op)
            suf_pkg::CELL_HOLD:
            begin
            end
            suf_pkg::CELL_INSERT:
            begin
                // Smaller entries stay; the first larger slot takes the new
                // value and every later slot takes its left neighbor.
                if (!lt)
                begin
                    value_next = (IS_HEAD || left_lt) ? ctrl.value : left_value;
                end
            end
            suf_pkg::CELL_DELETE:
            begin
                if (!lt)
                begin
                    value_next = right_value;
                end
            end
            suf_pkg::CELL_MARK:
            begin
                drop_next = !occupied || suf_pkg::drop_match(ctrl.kind, value_reg);
            end
            suf_pkg::CELL_SWAP:
            begin
                // Odd-even transposition: a dropped entry trades places with a
                // kept neighbor on its right, so kept entries keep their order.
                if (HAS_RIGHT && (ctrl.parity == RIGHT_PAR) && drop_reg && !right_drop)
                begin
                    value_next = right_value;
                    drop_next  = 1'b0;
                end
                else if (HAS_LEFT && (ctrl.parity == LEFT_PAR) && left_drop && !drop_reg)
                begin
                    value_next = left_value;
                    drop_next  = 1'b1;
                end
            end
            suf_pkg::CELL_ROTATE:
            begin
                value_next = right_value;
            end
            default:
            begin
            end
        endcase
    end

    // Entry and mark storage.
    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
        drop_reg  <= drop_next;
    end

endmodule

`default_nettype wire

FILE: hw/rtl/suf_chain.sv
// Row of storage cells with the neighbor wiring and chain-wide summaries.
`default_nettype none

module suf_chain #(
    parameter int CAPACITY = suf_pkg::CAPACITY_DEF,
    parameter int CNT_W    = $clog2(CAPACITY + 1)
) (
    input  wire                          clk,
    input  wire  suf_pkg::cell_ctrl_t    ctrl,
    input  wire  [CNT_W-1:0]             count,
    output logic                         match,
    output logic [CNT_W-1:0]             kept_count,
    output logic [suf_pkg::DATA_W-1:0]   head_value
);

    logic [suf_pkg::DATA_W-1:0] vals [CAPACITY];
    logic [CAPACITY-1:0]        lts;
    logic [CAPACITY-1:0]        eqs;
    logic [CAPACITY:0]          drops;

    // Cells; the last one closes the ring to the head for rotation.
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        suf_cell #(
            .CAPACITY (CAPACITY),
            .INDEX    (i),
            .CNT_W    (CNT_W)
        ) u_cell (
            .clk         (clk),
            .ctrl        (ctrl),
            .count       (count),
            .left_value  ((i == 0) ? '0 : vals[(i == 0) ? 0 : i - 1]),
            .left_lt     ((i == 0) ? 1'b0 : lts[(i == 0) ? 0 : i - 1]),
            .left_drop   ((i == 0) ? 1'b1 : drops[(i == 0) ? 0 : i - 1]),
            .right_value (vals[(i + 1) % CAPACITY]),
            .right_drop  (drops[i + 1]),
            .value       (vals[i]),
            .lt          (lts[i]),
            .eq          (eqs[i]),
            .drop        (drops[i])
        );
    end

    // Position past the chain counts as dropped.
    assign drops[CAPACITY] = 1'b1;

    assign match      = |eqs;
    assign head_value = vals[0];

    // After compaction the kept entries form a prefix; its end gives the count.
    always_comb
    begin
        kept_count = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            if (!drops[i] && drops[i + 1])
            begin
                kept_count = kept_count | CNT_W'(i + 1);
            end
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/suf_checker.sv
// Port-level checks of the set filter and the bind that attaches them.
`default_nettype none

`include "assert_macros.svh"

module suf_checker (
    input wire                            clk,
    input wire                            rst_n,
    input wire                            s_tvalid,
    input wire                            s_tready,
    input wire [suf_pkg::DATA_W-1:0]      s_tdata,
    input wire [suf_pkg::CMD_W-1:0]       s_tuser,
    input wire                            m_tvalid,
    input wire                            m_tready,
    input wire [suf_pkg::DATA_W-1:0]      m_tdata,
    input wire [suf_pkg::STATUS_W-1:0]    m_tuser,
    input wire                            m_tlast
);

    logic in_xfer;
    logic not_entry;
    logic cmd_seen;
    logic [suf_pkg::DATA_W+suf_pkg::STATUS_W:0] out_bits;

    assign in_xfer   = s_tvalid && s_tready;
    assign not_entry = (m_tuser != suf_pkg::ST_ENTRY);
    assign cmd_seen  = (s_tdata == s_tdata) && (s_tuser == s_tuser);
    assign out_bits  = {m_tdata, m_tuser, m_tlast};

    // A stalled result holds its contents.
    `ASSERT_DEF(a_out_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(out_bits))

    // Only a list entry carries a value.
    `ASSERT_DEF(a_entry_zero, m_tvalid && not_entry |-> m_tdata == '0)

    // Every result other than a list entry closes its command.
    `ASSERT_DEF(a_single_last, m_tvalid && not_entry |-> m_tlast)

    // A command keeps the block busy in the cycle after its transfer.
    `ASSERT_DEF(a_busy_after_cmd, in_xfer && cmd_seen |=> !s_tready)

endmodule

bind sorted_unique_set_filter suf_checker u_suf_checker (.*);

`default_nettype wire

FILE: sim/tb_sorted_unique_set_filter.sv
// Self-checking testbench for the sorted unique set filter: directed and random command traffic.
module tb_sorted_unique_set_filter;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CAPACITY     = suf_pkg::CAPACITY_DEF;
    localparam int IDLE_PCT     = 31;
    localparam int MAX_SHOWN    = 10;
    localparam int DRAIN_CYCLES = 2 * CAPACITY + 8;

    // Command codes that the block does not define; they must act as a no-op.
    localparam logic [suf_pkg::CMD_W-1:0] CMD_SPARE_A = 3'd6;
    localparam logic [suf_pkg::CMD_W-1:0] CMD_SPARE_B = 3'd7;

    localparam logic signed [suf_pkg::DATA_W-1:0] VAL_MIN = 32'sh8000_0000;
    localparam logic signed [suf_pkg::DATA_W-1:0] VAL_MAX = 32'sh7fff_ffff;

    typedef struct packed {
        suf_pkg::status_t           status;
        logic [suf_pkg::DATA_W-1:0] entry;
        logic                       last;
    } set_result_t;

    logic                           clk      = 1'b0;
    logic                           rst_n    = 1'b0;
    logic                           s_tvalid = 1'b0;
    logic                           s_tready;
    logic [suf_pkg::DATA_W-1:0]     s_tdata  = '0;
    logic [suf_pkg::CMD_W-1:0]      s_tuser  = '0;
    logic                           m_tvalid;
    logic                           m_tready = 1'b0;
    logic [suf_pkg::DATA_W-1:0]     m_tdata;
    logic [suf_pkg::STATUS_W-1:0]   m_tuser;
    logic                           m_tlast;

    // Shadow copy of the stored set and the results still to arrive.
    logic signed [suf_pkg::DATA_W-1:0] set_vals[$];
    set_result_t                       pending_results[$];

    bit gaps_on    = 1'b1;
    int mismatches = 0;

    always #2 clk = ~clk;

    sorted_unique_set_filter i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    task automatic flag_result_error(input string msg);
        mismatches++;
        if (mismatches <= MAX_SHOWN)
        begin
            $display("mismatch at %0t: %s", $realtime, msg);
        end
    endtask

    function automatic void expect_result(input suf_pkg::status_t st,
                                          input logic [suf_pkg::DATA_W-1:0] val,
                                          input logic fin);
        pending_results.push_back('{status: st, entry: val, last: fin});
    endfunction

    // Apply one command to the shadow set and queue the results it must produce.
    function automatic void predict_command(input logic [suf_pkg::CMD_W-1:0] code,
                                            input logic signed [suf_pkg::DATA_W-1:0] operand);
        int pos;
        bit gone;
        logic signed [suf_pkg::DATA_W-1:0] kept[$];
        pos = 0;
        case (code)
            suf_pkg::CMD_INSERT:
            begin
                while (pos < set_vals.size() && set_vals[pos] < operand)
                begin
                    pos++;
                end
                // A present value is reported as a duplicate even when the set is full.
                if (pos < set_vals.size() && set_vals[pos] == operand)
                begin
                    expect_result(suf_pkg::ST_DUP, '0, 1'b1);
                end
                else if (set_vals.size() >= CAPACITY)
                begin
                    expect_result(suf_pkg::ST_FULL, '0, 1'b1);
                end
                else
                begin
                    set_vals.insert(pos, operand);
                    expect_result(suf_pkg::ST_DONE, '0, 1'b1);
                end
            end
            suf_pkg::CMD_DELETE:
            begin
                while (pos < set_vals.size() && set_vals[pos] != operand)
                begin
                    pos++;
                end
                if (pos < set_vals.size())
                begin
                    set_vals.delete(pos);
                    expect_result(suf_pkg::ST_DONE, '0, 1'b1);
                end
                else
                begin
                    expect_result(suf_pkg::ST_NOTFOUND, '0, 1'b1);
                end
            end
            suf_pkg::CMD_DROP_POS, suf_pkg::CMD_DROP_NEG, suf_pkg::CMD_DROP_EVN:
            begin
                // Zero survives every filter; order of the kept values is unchanged.
                foreach (set_vals[i])
                begin
                    case (code)
                        suf_pkg::CMD_DROP_POS: gone = set_vals[i] > 0;
                        suf_pkg::CMD_DROP_NEG: gone = set_vals[i] < 0;
                        default:               gone = set_vals[i] != 0 && !set_vals[i][0];
                    endcase
                    if (!gone)
                    begin
                        kept.push_back(set_vals[i]);
                    end
                end
                set_vals = kept;
                expect_result(suf_pkg::ST_DONE, '0, 1'b1);
            end
            suf_pkg::CMD_LIST:
            begin
                if (set_vals.size() == 0)
                begin
                    expect_result(suf_pkg::ST_EMPTY, '0, 1'b1);
                end
                foreach (set_vals[i])
                begin
                    expect_result(suf_pkg::ST_ENTRY, set_vals[i], i == set_vals.size() - 1);
                end
            end
            default:
            begin
                expect_result(suf_pkg::ST_DONE, '0, 1'b1);
            end
        endcase
    endfunction

    // Send one command on the slave side, with random idle cycles before it when gaps are on.
    task automatic send_command(input logic [suf_pkg::CMD_W-1:0] code,
                                input logic signed [suf_pkg::DATA_W-1:0] operand);
        @(negedge clk);
        while (gaps_on && $urandom_range(99) < IDLE_PCT)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= code;
        s_tdata  <= operand;
        do
        begin
            @(posedge clk);
        end
        while (!s_tready);
        predict_command(code, operand);
    endtask

    // A small pool near zero, the extremes and random words, so that duplicates and hits are common.
    function automatic logic signed [suf_pkg::DATA_W-1:0] pick_value();
        int r;
        logic signed [suf_pkg::DATA_W-1:0] v;
        r = $urandom_range(99);
        if (r < 40)
        begin
            v = $urandom_range(16) - 8;
        end
        else if (r < 50)
        begin
            case ($urandom_range(5))
                0:       v = VAL_MIN;
                1:       v = VAL_MIN + 1;
                2:       v = VAL_MAX;
                3:       v = VAL_MAX - 1;
                4:       v = -1;
                default: v = 0;
            endcase
        end
        else
        begin
            v = $urandom();
        end
        return v;
    endfunction

    function automatic logic signed [suf_pkg::DATA_W-1:0] pick_stored_value();
        logic signed [suf_pkg::DATA_W-1:0] v;
        if (set_vals.size() == 0)
        begin
            v = pick_value();
        end
        else
        begin
            v = set_vals[$urandom_range(set_vals.size() - 1)];
        end
        return v;
    endfunction

    // Every command but insert against an empty set, including the undefined codes.
    task automatic test_empty_set();
        send_command(suf_pkg::CMD_LIST, 0);
        send_command(suf_pkg::CMD_DELETE, 0);
        send_command(suf_pkg::CMD_DROP_POS, 0);
        send_command(suf_pkg::CMD_DROP_NEG, -1);
        send_command(suf_pkg::CMD_DROP_EVN, VAL_MAX);
        send_command(CMD_SPARE_A, VAL_MIN);
        send_command(CMD_SPARE_B, -1);
    endtask

    // Extreme and near-zero values, a duplicate, a hit and a miss on delete.
    task automatic test_extreme_values();
        send_command(suf_pkg::CMD_INSERT, VAL_MIN);
        send_command(suf_pkg::CMD_INSERT, VAL_MAX);
        send_command(suf_pkg::CMD_INSERT, 0);
        send_command(suf_pkg::CMD_INSERT, -1);
        send_command(suf_pkg::CMD_INSERT, 1);
        send_command(suf_pkg::CMD_INSERT, 2);
        send_command(suf_pkg::CMD_INSERT, -2);
        send_command(suf_pkg::CMD_INSERT, VAL_MAX);
        send_command(suf_pkg::CMD_LIST, 0);
        send_command(suf_pkg::CMD_DELETE, -1);
        send_command(suf_pkg::CMD_DELETE, 12345);
    endtask

    // Each bulk filter on a mixed set; zero must remain at the end.
    task automatic test_bulk_filters();
        send_command(suf_pkg::CMD_DROP_NEG, 0);
        send_command(suf_pkg::CMD_LIST, 0);
        send_command(suf_pkg::CMD_DROP_EVN, 0);
        send_command(suf_pkg::CMD_DROP_POS, 0);
        send_command(suf_pkg::CMD_LIST, 0);
    endtask

    // Fill the set, then probe full-set behavior and a filter on a full or nearly full set.
    task automatic test_fill_to_capacity();
        while (set_vals.size() < CAPACITY)
        begin
            send_command(suf_pkg::CMD_INSERT, pick_value());
        end
        send_command(suf_pkg::CMD_INSERT, $urandom());
        send_command(suf_pkg::CMD_INSERT, pick_stored_value());
        send_command(suf_pkg::CMD_LIST, $urandom());
        send_command(suf_pkg::CMD_DELETE, pick_stored_value());
        send_command(suf_pkg::CMD_INSERT, pick_value());
        send_command(suf_pkg::CMD_DROP_EVN, $urandom());
        send_command(suf_pkg::CMD_LIST, $urandom());
    endtask

    // Weighted random commands, insert-heavy so that the set reaches full often.
    task automatic test_random_traffic(input int n_items);
        int r;
        for (int k = 0; k < n_items; k++)
        begin
            r = $urandom_range(99);
            if (r < 40)
            begin
                send_command(suf_pkg::CMD_INSERT, pick_value());
            end
            else if (r < 60)
            begin
                send_command(suf_pkg::CMD_DELETE,
                             ($urandom_range(99) < 70) ? pick_stored_value() : pick_value());
            end
            else if (r < 63)
            begin
                send_command(suf_pkg::CMD_DROP_POS, $urandom());
            end
            else if (r < 66)
            begin
                send_command(suf_pkg::CMD_DROP_NEG, $urandom());
            end
            else if (r < 69)
            begin
                send_command(suf_pkg::CMD_DROP_EVN, $urandom());
            end
            else if (r < 87)
            begin
                send_command(suf_pkg::CMD_LIST, $urandom());
            end
            else if (r < 90)
            begin
                send_command($urandom_range(1) ? CMD_SPARE_A : CMD_SPARE_B, $urandom());
            end
            else
            begin
                send_command(suf_pkg::CMD_INSERT, pick_stored_value());
            end
        end
    endtask

    // Back-to-back transfers on both sides with no idle cycles.
    task automatic test_steady_stream();
        gaps_on = 1'b0;
        test_fill_to_capacity();
        test_random_traffic(30);
        gaps_on = 1'b1;
    endtask

    // Result-side flow control.
    always @(negedge clk)
    begin
        m_tready <= !gaps_on || ($urandom_range(99) >= IDLE_PCT);
    end

    // Compare every result transfer with the oldest expectation.
    always @(posedge clk)
    begin
        set_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_results.size() == 0)
            begin
                flag_result_error($sformatf("unexpected result status %0d entry %0d last %0b",
                                            m_tuser, $signed(m_tdata), m_tlast));
            end
            else
            begin
                want = pending_results.pop_front();
                if (m_tuser !== want.status || m_tdata !== want.entry || m_tlast !== want.last)
                begin
                    flag_result_error($sformatf(
                        "status %0d entry %0d last %0b, expected %0d %0d %0b",
                        m_tuser, $signed(m_tdata), m_tlast,
                        want.status, $signed(want.entry), want.last));
                end
            end
        end
    end

    initial
    begin
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;

        test_empty_set();
        test_extreme_values();
        test_bulk_filters();
        test_fill_to_capacity();
        test_random_traffic(40);
        test_steady_stream();
        test_random_traffic(30);

        @(negedge clk);
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0)
        begin
            $display("tb: success");
        end
        else
        begin
            $display("tb: failure");
        end
        $finish;
    end

    // Watchdog for a hung handshake.
    initial
    begin
        #2ms;
        $display("tb: failure");
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+hw/rtl
hw/rtl/suf_pkg.sv
hw/rtl/suf_cell.sv
hw/rtl/suf_chain.sv
hw/rtl/sorted_unique_set_filter.sv
hw/rtl/suf_checker.sv
sim/tb_sorted_unique_set_filter.sv
